@@ rtl/csl_pkg.sv @@
// Shared types and constants of the calibrated sample low-pass block.
// Used by csl_alu, csl_cfg and calibrated_sample_lowpass; depends on nothing.
package csl_pkg;

    // Field widths of the stream and register payloads.
    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 16;
    localparam int TF_W     = 24;
    localparam int TS_W     = 32;
    localparam int VALUE_W  = 32;
    localparam int STATE_W  = 48;

    // Internal datapath widths.
    localparam int ALU_W    = 68;   // holds d * dt with sign
    localparam int S_W      = 26;   // scaled sample, signed
    localparam int DT_W     = 19;   // clamped time gap
    localparam int DVSR_W   = 25;   // filter_time_us + dt
    localparam int QUO_W    = 49;   // quotient magnitude
    localparam int CNT_W    = 6;

    localparam int MUL_STEPS = DT_W;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [TS_W-1:0] DT_LIMIT_US    = 32'd500000;
    localparam logic [DT_W-1:0] DT_FALLBACK_US = 19'd1000;
    localparam logic [7:0]      ROUND_BIAS     = 8'hFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_GAIN = 2'd0;
    localparam logic [1:0] REG_TF   = 2'd1;
    localparam logic [1:0] REG_SCP  = 2'd2;

    typedef enum logic [1:0] {
        OP_CHAN_A = 2'd0,
        OP_CHAN_B = 2'd1,
        OP_DIFF   = 2'd2,
        OP_ALT_A  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL,
        ST_MUL,
        ST_RNDS,
        ST_DT,
        ST_DVSR,
        ST_DIFF,
        ST_ABS,
        ST_DIV,
        ST_SUM,
        ST_RNDY,
        ST_OUT
    } csl_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [TF_W-1:0]   filter_time_us;
        logic              second_channel_present;
    } cfg_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

@@ rtl/calibrated_sample_lowpass.sv @@
// Top level of the calibrated sample low-pass block: sequencer and datapath.
// Depends on csl_pkg, csl_alu (shared adder) and csl_cfg (register port).
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tdata: operation, sample_a, sample_b, timestamp_us
//  m_        out        m_tvalid/m_tready  m_tdata: value (signed 32 bits)
//  APB       in         psel/penable       gain, filter_time_us, second_channel_present
//
// With the filter off an item runs only the gain path; with the filter on it also
// runs the filter update. All data arithmetic goes through the single shared 68-bit adder: a
// 19-step shift-add multiply for the gain, another 19 steps for (x - y) * dt and a
// 49-step restoring division by (Tf + dt), one adder pass per cycle.
// Reset is synchronous and active low; it clears the filter state and the timestamp.
// The block takes one transaction at a time; a finished result waits in the output
// register while the next transaction is accepted.
module calibrated_sample_lowpass
    import csl_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [13:2] sample_a, [25:14] sample_b, [57:26] timestamp_us, rest zero
    input  logic [63:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] value
    output logic [31:0] m_tdata
);

    // Only the low SAMPLE_BITS bits of a sample count, capped at the field width.
    localparam int USED_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SMASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - USED_W);

    localparam logic signed [39:0] SAT_HI = 40'sh00_7FFF_FFFF;
    localparam logic signed [39:0] SAT_LO = 40'shFF_8000_0000;

    cfg_t             cfg;
    alu_req_t         alu_req;
    logic [ALU_W-1:0] alu_sum;

    csl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csl_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    csl_state_t          state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [SAMPLE_W-1:0] a_reg, a_next;
    logic [SAMPLE_W-1:0] b_reg, b_next;
    logic [TS_W-1:0]     ts_reg, ts_next;
    logic [ALU_W-1:0]    mcand_reg, mcand_next;
    logic [DT_W-1:0]     mplier_reg, mplier_next;
    logic [ALU_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                phase_reg, phase_next;   // 0: gain multiply, 1: filter multiply
    logic [S_W-1:0]      s_reg, s_next;
    logic [DT_W-1:0]     dt_reg, dt_next;
    logic [DVSR_W-1:0]   divisor_reg, divisor_next;
    logic [DVSR_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic                neg_reg, neg_next;
    logic [STATE_W-1:0]  fv_reg, fv_next;
    logic [TS_W-1:0]     last_ts_reg, last_ts_next;
    logic [VALUE_W-1:0]  result_reg, result_next;
    logic [VALUE_W-1:0]  m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;

    logic [DVSR_W:0]     trial;
    logic                trial_ge;
    logic signed [39:0]  y_div;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Partial remainder with the next dividend bit shifted in.
    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge = !alu_sum[ALU_W-1];
    assign y_div    = alu_sum[47:8];

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        ts_next      = ts_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        phase_next   = phase_reg;
        s_next       = s_reg;
        dt_next      = dt_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        fv_next      = fv_reg;
        last_ts_next = last_ts_reg;
        result_next  = result_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        alu_req      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tdata[1:0]);
                    a_next     = s_tdata[13:2] & SMASK;
                    b_next     = s_tdata[25:14] & SMASK;
                    ts_next    = s_tdata[57:26];
                    state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                // Pick a channel or B minus A; a missing B reads as A, or zero in B minus A.
                case (op_reg)
                    OP_CHAN_B: begin
                        alu_req.a = ALU_W'(cfg.second_channel_present ? b_reg : a_reg);
                    end
                    OP_DIFF: begin
                        alu_req.a   = ALU_W'(cfg.second_channel_present ? b_reg : '0);
                        alu_req.b   = ALU_W'(a_reg);
                        alu_req.sub = 1'b1;
                    end
                    default: begin
                        alu_req.a = ALU_W'(a_reg);
                    end
                endcase
                mcand_next  = alu_sum;
                mplier_next = DT_W'(cfg.gain);
                acc_next    = '0;
                cnt_next    = '0;
                phase_next  = 1'b0;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                // Shift-add multiply of a signed multiplicand by an unsigned multiplier.
                alu_req.a   = acc_reg;
                alu_req.b   = mplier_reg[0] ? mcand_reg : '0;
                acc_next    = alu_sum;
                mcand_next  = {mcand_reg[ALU_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[DT_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    state_next = phase_reg ? ST_ABS : ST_RNDS;
                end
            end
            ST_RNDS: begin
                // Divide by 256 toward zero: bias negative values before the shift.
                alu_req.a   = acc_reg;
                alu_req.b   = ALU_W'(acc_reg[ALU_W-1] ? ROUND_BIAS : 8'd0);
                s_next      = alu_sum[S_W+7:8];
                result_next = alu_sum[VALUE_W+7:8];
                state_next  = (cfg.filter_time_us == '0) ? ST_OUT : ST_DT;
            end
            ST_DT: begin
                alu_req.a   = ALU_W'(ts_reg);
                alu_req.b   = ALU_W'(last_ts_reg);
                alu_req.sub = 1'b1;
                if (alu_sum[TS_W-1:0] > DT_LIMIT_US) begin
                    dt_next = DT_FALLBACK_US;
                end else begin
                    dt_next = alu_sum[DT_W-1:0];
                end
                state_next = ST_DVSR;
            end
            ST_DVSR: begin
                alu_req.a    = ALU_W'(cfg.filter_time_us);
                alu_req.b    = ALU_W'(dt_reg);
                divisor_next = alu_sum[DVSR_W-1:0];
                state_next   = ST_DIFF;
            end
            ST_DIFF: begin
                // d = s * 256 - y_prev, then multiply d by dt.
                alu_req.a   = {{(ALU_W-S_W-8){s_reg[S_W-1]}}, s_reg, 8'd0};
                alu_req.b   = {{(ALU_W-STATE_W){fv_reg[STATE_W-1]}}, fv_reg};
                alu_req.sub = 1'b1;
                mcand_next  = alu_sum;
                mplier_next = dt_reg;
                acc_next    = '0;
                cnt_next    = '0;
                phase_next  = 1'b1;
                state_next  = ST_MUL;
            end
            ST_ABS: begin
                // Divide magnitudes; the sign is applied when the state is updated.
                neg_next    = acc_reg[ALU_W-1];
                alu_req.a   = acc_reg[ALU_W-1] ? '0 : acc_reg;
                alu_req.b   = acc_reg[ALU_W-1] ? acc_reg : '0;
                alu_req.sub = acc_reg[ALU_W-1];
                // The quotient fits QUO_W bits, so the upper dividend bits start below
                // the divisor.
                rem_next    = DVSR_W'(alu_sum[ALU_W-1:QUO_W]);
                quo_next    = alu_sum[QUO_W-1:0];
                cnt_next    = '0;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                alu_req.a   = ALU_W'(trial);
                alu_req.b   = ALU_W'(divisor_reg);
                alu_req.sub = 1'b1;
                rem_next    = trial_ge ? alu_sum[DVSR_W-1:0] : trial[DVSR_W-1:0];
                quo_next    = {quo_reg[QUO_W-2:0], trial_ge};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                alu_req.a    = {{(ALU_W-STATE_W){fv_reg[STATE_W-1]}}, fv_reg};
                alu_req.b    = ALU_W'(quo_reg);
                alu_req.sub  = neg_reg;
                fv_next      = alu_sum[STATE_W-1:0];
                last_ts_next = ts_reg;
                state_next   = ST_RNDY;
            end
            ST_RNDY: begin
                alu_req.a = {{(ALU_W-STATE_W){fv_reg[STATE_W-1]}}, fv_reg};
                alu_req.b = ALU_W'(fv_reg[STATE_W-1] ? ROUND_BIAS : 8'd0);
                if (y_div > SAT_HI) begin
                    result_next = SAT_HI[VALUE_W-1:0];
                end else if (y_div < SAT_LO) begin
                    result_next = SAT_LO[VALUE_W-1:0];
                end else begin
                    result_next = y_div[VALUE_W-1:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = result_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            fv_reg      <= '0;
            last_ts_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            fv_reg      <= fv_next;
            last_ts_reg <= last_ts_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        ts_reg      <= ts_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        phase_reg   <= phase_next;
        s_reg       <= s_next;
        dt_reg      <= dt_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        result_reg  <= result_next;
        m_data_reg  <= m_data_next;
    end

    // An accepted transaction keeps the input closed while it is worked on.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready while a transaction is in progress");

    // The filter path is entered only with a nonzero time constant.
    a_filter_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DT) |-> (cfg.filter_time_us != '0))
        else $error("filter step taken with the filter disabled");

    // Restoring division keeps the partial remainder below the divisor.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < divisor_reg))
        else $error("division remainder out of range");

    // The multiply loop never runs past its step count.
    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (cnt_reg < CNT_W'(MUL_STEPS)))
        else $error("multiply step counter overran");

endmodule

@@ rtl/csl_alu.sv @@
// Shared add/subtract unit of the calibrated sample low-pass block.
// Depends on csl_pkg for the operand width and request struct.
module csl_alu
    import csl_pkg::*;
(
    input  alu_req_t         req,
    output logic [ALU_W-1:0] sum
);

    // Each data add or subtract of the sequencer passes through this one adder.
    assign sum = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

@@ rtl/csl_cfg.sv @@
// APB-style configuration registers of the calibrated sample low-pass block.
// Depends on csl_pkg for the register indexes and the cfg_t struct.
module csl_cfg
    import csl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_GAIN: cfg_next.gain = pwdata[GAIN_W-1:0];
                REG_TF:   cfg_next.filter_time_us = pwdata[TF_W-1:0];
                REG_SCP:  cfg_next.second_channel_present = pwdata[0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GAIN: prdata = {{(32-GAIN_W){1'b0}}, cfg_reg.gain};
            REG_TF:   prdata = {{(32-TF_W){1'b0}}, cfg_reg.filter_time_us};
            REG_SCP:  prdata = {31'd0, cfg_reg.second_channel_present};
            default:  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain                   <= 16'd256;
            cfg_reg.filter_time_us         <= '0;
            cfg_reg.second_channel_present <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
